// File: rtl/core/json_string_unescape_utf8_core_defines.svh
// Assertion macros shared by the JSON string unescaper RTL.
// Needs clk and rst_n in scope at the point of use.
`ifndef JSON_STRING_UNESCAPE_UTF8_CORE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/jsu_pkg.sv
// Shared types for the JSON string unescaper: result kinds and queue entry.
// No dependencies.
package jsu_pkg;

  // Kind of one result item
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  localparam int unsigned MAX_BYTES = 4;

  // Everything one input byte produces: up to four UTF-8 bytes, then
  // optionally a done or error marker.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;   // bytes[0] goes out first
    logic [2:0]                nbytes;  // 0..4
    logic                      has_tail;
    kind_t                     tail_kind;
  } entry_t;

endpackage

// File: rtl/core/jsu_front.sv
// Front end: accepts raw bytes, runs the escape parser and builds at most one
// queue entry per byte. Depends on jsu_pkg.
module jsu_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  logic [7:0]      in_byte,
  input  logic            in_end,
  output logic            push,
  output jsu_pkg::entry_t push_data
);

  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_STR  = 3'd1,
    M_ESC  = 3'd2,
    M_HEX1 = 3'd3,
    M_WBS  = 3'd4,
    M_WU   = 3'd5,
    M_HEX2 = 3'd6
  } mode_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_U     = 8'h75;

  mode_t        mode_r, mode_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic [15:0]  acc_r, acc_nxt;
  logic [9:0]   hs_r, hs_nxt;

  // Hex digit decode; bit 4 set means not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      v = {1'b0, c[3:0] + 4'd9};
    return v;
  endfunction

  // UTF-8 encoder for a code point up to 0x10FFFF
  function automatic jsu_pkg::entry_t utf8(input logic [20:0] cp);
    jsu_pkg::entry_t e;
    e = '0;
    e.tail_kind = jsu_pkg::KIND_BYTE;
    if (cp < 21'h80) begin
      e.bytes[0] = cp[7:0];
      e.nbytes   = 3'd1;
    end else if (cp < 21'h800) begin
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
      e.nbytes   = 3'd2;
    end else if (cp < 21'h10000) begin
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
      e.nbytes   = 3'd3;
    end else begin
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
      e.nbytes   = 3'd4;
    end
    return e;
  endfunction

  logic [4:0]      nib;
  logic            nib_ok;
  logic [15:0]     acc_dig;
  logic            quad_done;
  logic [10:0]     plane;
  jsu_pkg::entry_t ent;

  assign nib       = hex_val(in_byte);
  assign nib_ok    = !nib[4];
  assign acc_dig   = {acc_r[11:0], nib[3:0]};
  assign quad_done = nib_ok && (cnt_r == 2'd3);
  assign plane     = {1'b0, hs_r} + 11'h040;

  // Parser next state and entry build
  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    hs_nxt   = hs_r;
    ent      = '0;
    ent.tail_kind = jsu_pkg::KIND_BYTE;

    unique case (mode_r) inside
      M_STR: begin
        if (in_byte == CH_QUOTE) begin
          ent.has_tail  = 1'b1;
          ent.tail_kind = jsu_pkg::KIND_DONE;
          mode_nxt      = M_IDLE;
        end else if (in_byte == CH_BSL) begin
          mode_nxt = M_ESC;
        end else if (in_byte < 8'h20) begin
          ent.has_tail  = 1'b1;
          ent.tail_kind = jsu_pkg::KIND_ERR;
          mode_nxt      = M_IDLE;
        end else begin
          ent.bytes[0] = in_byte;
          ent.nbytes   = 3'd1;
        end
      end
      M_ESC: begin
        mode_nxt   = M_STR;
        ent.nbytes = 3'd1;
        unique case (in_byte) inside
          CH_QUOTE, CH_BSL, CH_SLASH: ent.bytes[0] = in_byte;
          8'h62: ent.bytes[0] = 8'h08;
          8'h66: ent.bytes[0] = 8'h0C;
          8'h6E: ent.bytes[0] = 8'h0A;
          8'h72: ent.bytes[0] = 8'h0D;
          8'h74: ent.bytes[0] = 8'h09;
          CH_U: begin
            ent.nbytes = 3'd0;
            mode_nxt   = M_HEX1;
            cnt_nxt    = 2'd0;
            acc_nxt    = 16'h0;
          end
          default: begin
            ent.nbytes    = 3'd0;
            ent.has_tail  = 1'b1;
            ent.tail_kind = jsu_pkg::KIND_ERR;
            mode_nxt      = M_IDLE;
          end
        endcase
      end
      M_HEX1, M_HEX2: begin
        if (!nib_ok) begin
          ent.has_tail  = 1'b1;
          ent.tail_kind = jsu_pkg::KIND_ERR;
          mode_nxt      = M_IDLE;
        end else begin
          acc_nxt = acc_dig;
          cnt_nxt = cnt_r + 2'd1;
          if (quad_done) begin
            if (mode_r == M_HEX1) begin
              // lone low surrogate is an error, a high one waits for its pair
              if (acc_dig[15:10] == 6'b110111) begin
                ent.has_tail  = 1'b1;
                ent.tail_kind = jsu_pkg::KIND_ERR;
                mode_nxt      = M_IDLE;
              end else if (acc_dig[15:10] == 6'b110110) begin
                hs_nxt   = acc_dig[9:0];
                mode_nxt = M_WBS;
              end else begin
                ent      = utf8({5'b0, acc_dig});
                mode_nxt = M_STR;
              end
            end else begin
              if (acc_dig[15:10] != 6'b110111) begin
                ent.has_tail  = 1'b1;
                ent.tail_kind = jsu_pkg::KIND_ERR;
                mode_nxt      = M_IDLE;
              end else begin
                ent      = utf8({plane, acc_dig[9:0]});
                mode_nxt = M_STR;
              end
            end
          end
        end
      end
      M_WBS: begin
        if (in_byte == CH_BSL) begin
          mode_nxt = M_WU;
        end else begin
          ent.has_tail  = 1'b1;
          ent.tail_kind = jsu_pkg::KIND_ERR;
          mode_nxt      = M_IDLE;
        end
      end
      M_WU: begin
        if (in_byte == CH_U) begin
          mode_nxt = M_HEX2;
          cnt_nxt  = 2'd0;
          acc_nxt  = 16'h0;
        end else begin
          ent.has_tail  = 1'b1;
          ent.tail_kind = jsu_pkg::KIND_ERR;
          mode_nxt      = M_IDLE;
        end
      end
      default: begin
        // idle: only an opening quote is accepted
        if (in_byte == CH_QUOTE) begin
          mode_nxt = M_STR;
        end else begin
          ent.has_tail  = 1'b1;
          ent.tail_kind = jsu_pkg::KIND_ERR;
          mode_nxt      = M_IDLE;
        end
      end
    endcase

    // end of text while a string is still open
    if (in_end && mode_nxt != M_IDLE) begin
      ent.has_tail  = 1'b1;
      ent.tail_kind = jsu_pkg::KIND_ERR;
      mode_nxt      = M_IDLE;
    end
  end

  assign push      = in_fire && (ent.nbytes != 3'd0 || ent.has_tail);
  assign push_data = ent;

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      cnt_r  <= 2'd0;
      acc_r  <= 16'h0;
      hs_r   <= 10'h0;
    end else if (in_fire) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
      hs_r   <= hs_nxt;
    end
  end

endmodule

// File: rtl/core/jsu_queue.sv
// Small FIFO of parsed entries between the front and back ends.
// Depends on jsu_pkg and the shared assertion macros.
`include "json_string_unescape_utf8_core_defines.svh"

module jsu_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  jsu_pkg::entry_t push_data,
  input  logic            pop,
  output jsu_pkg::entry_t pop_data,
  output logic            full,
  output logic            empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  jsu_pkg::entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (pop)  rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  `JSU_ASSERT_NOW(a_no_overflow, push, !full, "push into a full queue")
  `JSU_ASSERT_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + 1'b1, "count lost a push")

endmodule

// File: rtl/core/jsu_back.sv
// Back end: walks the head queue entry and sends its result items one per
// cycle while out_tready is high. Depends on jsu_pkg and the shared assertion macros.
`include "json_string_unescape_utf8_core_defines.svh"

module jsu_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  jsu_pkg::entry_t q_data,
  output logic            q_pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_tdata,
  output logic [1:0]      out_tuser,
  output logic            out_tlast
);

  logic [2:0] idx_r, idx_nxt;
  logic [2:0] total;
  logic       is_byte;
  logic       fire;

  assign total   = q_data.nbytes + {2'b0, q_data.has_tail};
  assign is_byte = (idx_r < q_data.nbytes);

  // Current result item
  assign out_tvalid = !q_empty;
  assign out_tdata  = is_byte ? q_data.bytes[idx_r[1:0]] : 8'h00;
  assign out_tuser  = is_byte ? jsu_pkg::KIND_BYTE : q_data.tail_kind;
  assign out_tlast  = (idx_r == total - 3'd1);

  assign fire    = out_tvalid && out_tready;
  assign q_pop   = fire && out_tlast;
  assign idx_nxt = q_pop ? 3'd0 : idx_r + 3'd1;

  // Position within the head entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
    end else if (fire) begin
      idx_r <= idx_nxt;
    end
  end

  `JSU_ASSERT_NOW(a_marker_last, out_tvalid && !is_byte, out_tlast, "done or error not last")
  `JSU_ASSERT_NEXT(a_entry_continues, fire && !out_tlast, out_tvalid, "entry dropped mid way")

endmodule

// File: rtl/core/json_string_unescape_utf8_core.sv
// JSON string unescaper: raw bytes in, UTF-8 bytes plus done/error items out.
// A taken byte's entry, if it makes one, is written into the entry queue;
// results leave from the queue head. Throughput: one input byte per cycle in
// while the queue is not full; results leave one per cycle while out_tready is
// high. The entry queue absorbs the difference; in_tready drops only when full.
// Reset: synchronous, active low; parser returns to idle, queue empties.
module json_string_unescape_utf8_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // in_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [1:0] out_kind
  output logic       out_tlast   // out_last
);

  logic            q_full, q_empty, q_push, q_pop;
  jsu_pkg::entry_t q_wdata, q_rdata;

  assign in_tready = !q_full;

  jsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_tvalid && in_tready),
    .in_byte   (in_tdata),
    .in_end    (in_tlast),
    .push      (q_push),
    .push_data (q_wdata)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench for json_string_unescape_utf8_core: sends raw JSON string bytes and
// checks every decoded byte, done and error item against a decoder kept in the bench.
// Depends on jsu_pkg and the core RTL only.
module tb_top;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam int unsigned GAP_PCT  = 23;

  // Decoder states; code 7 is never entered
  typedef enum logic [2:0] {
    ST_IDLE, ST_STRING, ST_ESCAPE, ST_QUAD1, ST_WANT_BSLASH, ST_WANT_U, ST_QUAD2
  } parse_st_t;

  typedef struct {
    logic [7:0]      data;
    jsu_pkg::kind_t  kind;
    logic            last;
  } result_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tready = 1'b0;
  logic       in_tready;
  logic       out_tvalid;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;

  // Bench copy of the decoder state
  parse_st_t   dec_st    = ST_IDLE;
  logic [1:0]  digit_cnt = 2'd0;
  logic [15:0] quad_acc  = 16'h0000;
  logic [9:0]  high_bits = 10'h000;
  result_t     step_res[$];
  result_t     decoded_q[$];

  bit          send_gaps   = 1'b1;
  bit          sink_stalls = 1'b1;
  int unsigned mismatches  = 0;
  int unsigned items_sent  = 0;

  logic [7:0] esc_letters [8] = '{CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t"};

  json_string_unescape_utf8_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] in_byte
    .in_tlast   (in_tlast),   // in_end
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [7:0] out_byte
    .out_tuser  (out_tuser),  // [1:0] out_kind
    .out_tlast  (out_tlast)   // out_last
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- decoder

  function automatic void add_result(logic [7:0] d, jsu_pkg::kind_t k);
    result_t r;
    r.data = d;
    r.kind = k;
    r.last = 1'b0;
    step_res.push_back(r);
  endfunction

  function automatic void parse_fault();
    add_result(8'h00, jsu_pkg::KIND_ERR);
    dec_st = ST_IDLE;
  endfunction

  function automatic void emit_utf8(logic [20:0] cp);
    if (cp < 21'h80) begin
      add_result(cp[7:0], jsu_pkg::KIND_BYTE);
    end else if (cp < 21'h800) begin
      add_result({3'b110, cp[10:6]}, jsu_pkg::KIND_BYTE);
      add_result({2'b10, cp[5:0]}, jsu_pkg::KIND_BYTE);
    end else if (cp < 21'h10000) begin
      add_result({4'b1110, cp[15:12]}, jsu_pkg::KIND_BYTE);
      add_result({2'b10, cp[11:6]}, jsu_pkg::KIND_BYTE);
      add_result({2'b10, cp[5:0]}, jsu_pkg::KIND_BYTE);
    end else begin
      add_result({5'b11110, cp[20:18]}, jsu_pkg::KIND_BYTE);
      add_result({2'b10, cp[17:12]}, jsu_pkg::KIND_BYTE);
      add_result({2'b10, cp[11:6]}, jsu_pkg::KIND_BYTE);
      add_result({2'b10, cp[5:0]}, jsu_pkg::KIND_BYTE);
    end
  endfunction

  // Nibble value, or 16 for a byte that is not a hex digit
  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      return {1'b0, c[3:0] + 4'd9};
    return 5'd16;
  endfunction

  // Works out the items one accepted byte causes and queues them
  function automatic void unescape_byte(logic [7:0] c, logic at_end);
    logic [4:0] nib;
    logic       quad_full;
    quad_full = 1'b0;
    case (dec_st)
      ST_STRING: begin
        if (c == CH_QUOTE) begin
          add_result(8'h00, jsu_pkg::KIND_DONE);
          dec_st = ST_IDLE;
        end else if (c == CH_BSLASH) begin
          dec_st = ST_ESCAPE;
        end else if (c < 8'h20) begin
          parse_fault();
        end else begin
          add_result(c, jsu_pkg::KIND_BYTE);
        end
      end
      ST_ESCAPE: begin
        dec_st = ST_STRING;
        case (c)
          CH_QUOTE, CH_BSLASH, "/": add_result(c, jsu_pkg::KIND_BYTE);
          "b": add_result(8'h08, jsu_pkg::KIND_BYTE);
          "f": add_result(8'h0C, jsu_pkg::KIND_BYTE);
          "n": add_result(8'h0A, jsu_pkg::KIND_BYTE);
          "r": add_result(8'h0D, jsu_pkg::KIND_BYTE);
          "t": add_result(8'h09, jsu_pkg::KIND_BYTE);
          CH_U: begin
            dec_st    = ST_QUAD1;
            digit_cnt = 2'd0;
            quad_acc  = 16'h0000;
          end
          default: parse_fault();
        endcase
      end
      ST_QUAD1, ST_QUAD2: begin
        nib = hex_nibble(c);
        if (nib[4]) begin
          parse_fault();
        end else begin
          quad_acc  = {quad_acc[11:0], nib[3:0]};
          quad_full = (digit_cnt == 2'd3);
          digit_cnt = digit_cnt + 2'd1;  // wraps to zero after the fourth digit
        end
        if (quad_full && dec_st == ST_QUAD1) begin
          if (quad_acc >= 16'hDC00 && quad_acc <= 16'hDFFF) begin
            parse_fault();
          end else if (quad_acc >= 16'hD800 && quad_acc <= 16'hDBFF) begin
            high_bits = quad_acc[9:0];
            dec_st    = ST_WANT_BSLASH;
          end else begin
            emit_utf8({5'd0, quad_acc});
            dec_st = ST_STRING;
          end
        end else if (quad_full) begin
          if (quad_acc < 16'hDC00 || quad_acc > 16'hDFFF) begin
            parse_fault();
          end else begin
            emit_utf8(21'h10000 + {1'b0, high_bits, quad_acc[9:0]});
            dec_st = ST_STRING;
          end
        end
      end
      ST_WANT_BSLASH: begin
        if (c == CH_BSLASH) dec_st = ST_WANT_U;
        else parse_fault();
      end
      ST_WANT_U: begin
        if (c == CH_U) begin
          dec_st    = ST_QUAD2;
          digit_cnt = 2'd0;
          quad_acc  = 16'h0000;
        end else begin
          parse_fault();
        end
      end
      default: begin
        if (c == CH_QUOTE) dec_st = ST_STRING;
        else add_result(8'h00, jsu_pkg::KIND_ERR);
      end
    endcase
    // text ran out before the string closed
    if (at_end && dec_st != ST_IDLE) parse_fault();
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) decoded_q.push_back(step_res[i]);
    step_res.delete();
  endfunction

  // ---------------------------------------------------------------- result side

  always @(posedge clk) out_tready <= !sink_stalls || ($urandom_range(99) >= GAP_PCT);

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected item: out_byte %02h out_kind %0d out_last %0b",
               out_tdata, out_tuser, out_tlast);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        if (out_tdata !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, out_tdata);
          mismatches++;
        end
        if (out_tuser !== want.kind) begin
          $error("out_kind: expected %0d, got %0d", want.kind, out_tuser);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $error("out_last: expected %0b, got %0b", want.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- input side

  task automatic send_item(logic [7:0] b, logic at_end);
    while (send_gaps && $urandom_range(99) < GAP_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= at_end;
    do @(posedge clk); while (!in_tready);
    unescape_byte(b, at_end);
    items_sent++;
  endtask

  // end flag goes on the final byte only
  task automatic send_text(string s, logic at_end);
    for (int i = 0; i < s.len(); i++) send_item(s[i], at_end && (i == s.len() - 1));
  endtask

  // Hold the input until every expected item has come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    logic [7:0] ch;
    if (n < 4'd10) ch = 8'h30 + n;
    else ch = 8'h61 + n - 8'd10;
    if (n >= 4'd10 && $urandom_range(1) == 1) ch = ch - 8'h20;  // upper case
    return ch;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    logic [4:0] nib;
    do begin
      b   = 8'($urandom_range(255));
      nib = hex_nibble(b);
    end while (!nib[4]);
    return b;
  endfunction

  function automatic logic [7:0] raw_text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255, 32)); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic bit known_escape(logic [7:0] b);
    case (b)
      CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t", CH_U: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [15:0] random_bmp();
    logic [15:0] v;
    case ($urandom_range(3))
      0:       v = 16'($urandom_range(16'h7F));
      1:       v = 16'($urandom_range(16'h7FF, 16'h80));
      default: v = 16'($urandom_range(16'hFFFF, 16'h800));
    endcase
    if (v >= 16'hD800 && v <= 16'hDFFF) v = v ^ 16'h4000;
    return v;
  endfunction

  // \u and the given number of leading hex digits of v
  task automatic send_quad(logic [15:0] v, int unsigned n_digits);
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_U, 1'b0);
    for (int i = 0; i < n_digits; i++) send_item(hex_char(v[4*(3-i) +: 4]), 1'b0);
  endtask

  // One fault that ends the current string
  task automatic send_broken_tail();
    logic [7:0]  b;
    logic [15:0] v;
    case ($urandom_range(5))
      0: send_item(8'($urandom_range(31)), 1'b0);
      1: begin
        do b = 8'($urandom_range(255)); while (known_escape(b));
        send_item(CH_BSLASH, 1'b0);
        send_item(b, 1'b0);
      end
      2: begin
        send_quad(16'($urandom), $urandom_range(3));
        send_item(non_hex_byte(), 1'b0);
      end
      3: send_quad(16'hDC00 | 16'($urandom_range(10'h3FF)), 4);
      4: begin
        // high surrogate followed by anything but a proper low one
        send_quad(16'hD800 | 16'($urandom_range(10'h3FF)), 4);
        case ($urandom_range(3))
          0: begin
            do b = 8'($urandom_range(255)); while (b == CH_BSLASH);
            send_item(b, 1'b0);
          end
          1: begin
            do b = 8'($urandom_range(255)); while (b == CH_U);
            send_item(CH_BSLASH, 1'b0);
            send_item(b, 1'b0);
          end
          2: begin
            send_quad(16'($urandom), $urandom_range(3));
            send_item(non_hex_byte(), 1'b0);
          end
          default: begin
            v = 16'($urandom);
            if (v >= 16'hDC00 && v <= 16'hDFFF) v = v ^ 16'h2000;
            send_quad(v, 4);
          end
        endcase
      end
      default: begin
        // text ends inside the string
        if ($urandom_range(1) == 1) send_item(raw_text_byte(), 1'b1);
        else send_item(CH_BSLASH, 1'b1);
      end
    endcase
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_framing();
    send_item("a", 1'b0);               // no opening quote
    send_item(CH_QUOTE, 1'b0);
    send_item(8'h20, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(CH_QUOTE, 1'b0);          // closes
    send_item(CH_QUOTE, 1'b0);
    send_item(8'h00, 1'b0);             // raw control byte
    send_item(CH_QUOTE, 1'b0);
    send_item(8'h1F, 1'b0);
    send_item(8'h00, 1'b0);
    wait_drained();
  endtask

  task automatic test_escapes();
    // all simple escapes, then an unknown letter and an upper-case U
    send_text("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\"", 1'b0);
    send_text("\"\\x", 1'b0);
    send_text("\"\\U", 1'b0);
    wait_drained();
  endtask

  task automatic test_unicode();
    // one, two and three byte boundaries in mixed case
    send_text("\"\\u0000\\u007F\\u0080\\u07ff\\u0800\\uFfFf\\u20ac\"", 1'b0);
    wait_drained();
  endtask

  task automatic test_surrogates();
    send_text("\"\\uD83D\\uDE00\\ud800\\udc00\\uDBFF\\uDFFF\"", 1'b0);
    send_text("\"\\uDC00", 1'b0);        // lone low surrogate
    send_text("\"\\uDFFF", 1'b0);
    send_text("\"\\uD800x", 1'b0);       // no backslash after high
    send_text("\"\\uDBFF\\n", 1'b0);     // backslash but not u
    send_text("\"\\uD800\\u0041", 1'b0); // low half out of range
    send_text("\"\\uD800\\uE000", 1'b0);
    send_text("\"\\u12G4", 1'b0);        // bad digit, first quad
    send_text("\"\\uD800\\uDC0g", 1'b0); // bad digit, second quad
    wait_drained();
  endtask

  task automatic test_end_of_text();
    send_text("\"ab", 1'b1);
    send_item(CH_QUOTE, 1'b1);
    send_text("\"\\", 1'b1);
    send_text("\"\\u00e", 1'b1);
    send_text("\"\\u00e9", 1'b1);
    send_text("\"\\uD83D\\uDE00", 1'b1); // four bytes then the error
    send_text("\"\\uD83D", 1'b1);
    send_text("\"ok\"", 1'b1);           // closed on the last byte: done only
    send_item("q", 1'b1);
    wait_drained();
  endtask

  // Mostly well-formed strings with random content, some broken
  task automatic test_random_strings(int unsigned n_items);
    int unsigned stop_at;
    int unsigned n_elem;
    int unsigned pick;
    bit          broken;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      broken = 1'b0;
      send_item(CH_QUOTE, 1'b0);
      n_elem = $urandom_range(10, 1);
      for (int i = 0; i < n_elem && !broken; i++) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          send_item(raw_text_byte(), 1'b0);
        end else if (pick < 63) begin
          send_item(CH_BSLASH, 1'b0);
          send_item(esc_letters[$urandom_range(7)], 1'b0);
        end else if (pick < 80) begin
          send_quad(random_bmp(), 4);
        end else if (pick < 90) begin
          send_quad(16'hD800 | 16'($urandom_range(10'h3FF)), 4);
          send_quad(16'hDC00 | 16'($urandom_range(10'h3FF)), 4);
        end else begin
          send_broken_tail();
          broken = 1'b1;
        end
      end
      if (!broken) send_item(CH_QUOTE, $urandom_range(3) == 0);
    end
    wait_drained();
  endtask

  // Arbitrary bytes, quotes strongly favored so strings get opened
  task automatic test_noise(int unsigned n_items);
    logic [7:0] b;
    for (int i = 0; i < n_items; i++) begin
      b = ($urandom_range(3) == 0) ? CH_QUOTE : 8'($urandom_range(255));
      send_item(b, $urandom_range(7) == 0);
    end
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_framing();
    test_escapes();
    test_unicode();
    test_surrogates();
    test_end_of_text();
    test_random_strings(130);
    // full rate on both sides
    send_gaps   = 1'b0;
    sink_stalls = 1'b0;
    test_random_strings(70);
    send_gaps   = 1'b1;
    sink_stalls = 1'b1;
    test_noise(60);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
